FILE: rtl/core/spmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_pkg
// shared types and constants of the slack priority multilevel queue
// ----------------------------------------------------------------------------
package spmq_pkg;

	localparam int LEVEL_W   = 4;
	localparam int TIME_W    = 48;
	localparam int ID_W      = 16;
	localparam int MISS_W    = 7;
	localparam int QL_W      = 6;
	localparam int ITHR_W    = 41;
	localparam int NRES_W    = 6;

	localparam logic [QL_W-1:0]   QL_RESET  = 6'd50;
	localparam logic [TIME_W-1:0] THR_RESET = 48'd50000;
	localparam logic [TIME_W-1:0] THR_MAX   = '1;
	localparam logic [NRES_W-1:0] NRES_LAST = '1;

	localparam logic REG_QUEUE_LIMIT = 1'b0;
	localparam logic REG_INIT_THR    = 1'b1;

	typedef enum logic [1:0] {
		EV_DELIVERED = 2'd0,
		EV_EXPIRED   = 2'd1,
		EV_OVERFLOW  = 2'd2,
		EV_NOTHING   = 2'd3
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_ALLOC,
		ST_LINK,
		ST_CHECK,
		ST_SCAN,
		ST_EMPTY,
		ST_POP_RD,
		ST_POP_WB
	} state_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] slack;
	} cls_req_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] level;
	} cls_res_t;

endpackage

FILE: rtl/core/slack_priority_multilevel_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slack_priority_multilevel_queue_core
// strict priority multilevel packet queue with adaptive slack threshold
// ----------------------------------------------------------------------------
// One item at a time; the input is ready only while the core is idle. An
// enqueue passes through slot allocation, link and check; a packet that
// needs slack classification first walks the thresholds from level 1 to at
// most NUM_LEVELS-2, and an overflow drop adds a head read and a write back.
// A dequeue scans the levels, then for each packet popped (expired drops and
// the delivery) reads the slot and link rams and writes the head back, or it
// reports empty when every level is empty. A result held by back-pressure
// stalls the core for as long as it waits.
// Slots are handed out from a free stack and a fill count; no clearing pass.
module slack_priority_multilevel_queue_core import spmq_pkg::*; #(
	parameter int NUM_LEVELS   = 8,
	parameter int PACKET_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// packet_id, has_delay_header, best_effort, slack, expiry_time, now
	input  logic [167:0] s_axis_tdata,
	// kind
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_packet_id, out_level
	output logic [23:0]  m_axis_tdata,
	// event_res
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int SW   = $clog2(PACKET_SLOTS);
	localparam int LIW  = $clog2(NUM_LEVELS);
	localparam int CW   = $clog2(PACKET_SLOTS + 1);
	localparam int CMPW = (CW > QL_W) ? CW : QL_W;
	localparam int DW   = ID_W + TIME_W + 1;
	localparam logic [CMPW-1:0] SLOT_CAP = CMPW'(PACKET_SLOTS - 1);
	localparam logic [LIW-1:0]  LVL_BE   = LIW'(NUM_LEVELS - 1);

	state_t state_q, state_n;

	logic [QL_W-1:0]   ql_q;
	logic [ITHR_W-1:0] ithr_q;
	logic              cfg_wr;

	logic              kind_q;
	logic [ID_W-1:0]   id_q;
	logic              hdr_q;
	logic [TIME_W-1:0] expiry_q;
	logic [TIME_W-1:0] now_q;
	logic [LIW-1:0]    lvl_q;
	logic [SW-1:0]     slot_q;
	logic [NRES_W-1:0] nres_q;

	logic [SW-1:0] head_q [NUM_LEVELS];
	logic [SW-1:0] tail_q [NUM_LEVELS];
	logic [CW-1:0] cnt_q  [NUM_LEVELS];
	logic [CW-1:0] total_q;
	logic [SW:0]   sp_q;
	logic [SW:0]   fresh_q;

	logic              out_valid_q;
	event_t            out_ev_q;
	logic [ID_W-1:0]   out_id_q;
	logic [LEVEL_W-1:0] out_lvl_q;
	logic              out_last_q;

	cls_req_t cls_req;
	cls_res_t cls_res;

	logic              in_xfer;
	logic              out_free;
	logic              out_load;
	logic [NUM_LEVELS-1:0] busy_lvl;
	logic [LIW-1:0]    hi_lvl;
	logic [LIW-1:0]    lo_lvl;
	logic              any_busy;
	logic [CMPW-1:0]   ql_ext;
	logic [CMPW-1:0]   eff_limit;
	logic              expired;

	logic          dram_we;
	logic          dram_re;
	logic [DW-1:0] dram_rdata;
	logic          lram_we;
	logic          lram_re;
	logic [SW-1:0] lram_rdata;
	logic          fram_we;
	logic          fram_re;
	logic [SW-1:0] fram_rdata;
	logic [SW-1:0] new_slot;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3])
			REG_QUEUE_LIMIT: prdata = 64'(ql_q);
			REG_INIT_THR:    prdata = 64'(ithr_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ql_q   <= QL_RESET;
			ithr_q <= ITHR_W'(THR_RESET);
		end else if (cfg_wr) begin
			if (paddr[3] == REG_QUEUE_LIMIT) begin
				ql_q <= pwdata[QL_W-1:0];
			end else begin
				ithr_q <= pwdata[ITHR_W-1:0];
			end
		end
	end

	// classifier
	assign cls_req.start = in_xfer && !s_axis_tuser[0] && s_axis_tdata[16] && !s_axis_tdata[17];
	assign cls_req.slack = s_axis_tdata[65:18];

	spmq_classify #(
		.NUM_LEVELS(NUM_LEVELS)
	) u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (cls_req),
		.queue_limit(ql_q),
		.thr_wr     (cfg_wr && (paddr[3] == REG_INIT_THR)),
		.thr_wdata  (TIME_W'(pwdata[ITHR_W-1:0])),
		.res        (cls_res)
	);

	// slot storage
	assign new_slot = (sp_q != '0) ? fram_rdata : fresh_q[SW-1:0];

	spmq_ram #(
		.WIDTH(DW),
		.DEPTH(PACKET_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (dram_we),
		.waddr(new_slot),
		.wdata({hdr_q, expiry_q, id_q}),
		.re   (dram_re),
		.raddr(head_q[lvl_q]),
		.rdata(dram_rdata)
	);

	spmq_ram #(
		.WIDTH(SW),
		.DEPTH(PACKET_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (lram_we),
		.waddr(tail_q[lvl_q]),
		.wdata(new_slot),
		.re   (lram_re),
		.raddr(head_q[lvl_q]),
		.rdata(lram_rdata)
	);

	spmq_ram #(
		.WIDTH(SW),
		.DEPTH(PACKET_SLOTS)
	) u_free_ram (
		.clk  (clk),
		.we   (fram_we),
		.waddr(sp_q[SW-1:0]),
		.wdata(slot_q),
		.re   (fram_re),
		.raddr(SW'(sp_q - (SW+1)'(1))),
		.rdata(fram_rdata)
	);

	// level search
	always_comb begin
		hi_lvl = '0;
		lo_lvl = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			busy_lvl[i] = cnt_q[i] != '0;
		end
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (busy_lvl[i]) begin
				hi_lvl = LIW'(i);
			end
		end
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (busy_lvl[i]) begin
				lo_lvl = LIW'(i);
			end
		end
		any_busy  = |busy_lvl;
		ql_ext    = CMPW'(ql_q);
		eff_limit = (ql_ext < SLOT_CAP) ? ql_ext : SLOT_CAP;
		expired   = dram_rdata[DW-1] && (now_q > dram_rdata[DW-2:ID_W]);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_EMPTY || state_q == ST_POP_WB) && out_free;

	always_comb begin
		state_n = state_q;
		dram_we = 1'b0;
		dram_re = 1'b0;
		lram_we = 1'b0;
		lram_re = 1'b0;
		fram_we = 1'b0;
		fram_re = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (s_axis_tuser[0]) begin
						state_n = ST_SCAN;
					end else if (cls_req.start) begin
						state_n = ST_CLASSIFY;
					end else begin
						state_n = ST_ALLOC;
					end
				end
			end
			ST_CLASSIFY: begin
				if (cls_res.done) begin
					state_n = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				fram_re = sp_q != '0;
				state_n = ST_LINK;
			end
			ST_LINK: begin
				dram_we = 1'b1;
				lram_we = cnt_q[lvl_q] != '0;
				state_n = ST_CHECK;
			end
			ST_CHECK: begin
				state_n = (CMPW'(total_q) > eff_limit) ? ST_POP_RD : ST_IDLE;
			end
			ST_SCAN: begin
				state_n = any_busy ? ST_POP_RD : ST_EMPTY;
			end
			ST_EMPTY: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			ST_POP_RD: begin
				dram_re = 1'b1;
				lram_re = 1'b1;
				state_n = ST_POP_WB;
			end
			ST_POP_WB: begin
				if (out_free) begin
					fram_we = 1'b1;
					if (kind_q && expired && (nres_q != NRES_LAST)) begin
						state_n = ST_SCAN;
					end else begin
						state_n = ST_IDLE;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q   <= s_axis_tuser[0];
			id_q     <= s_axis_tdata[15:0];
			hdr_q    <= s_axis_tdata[16];
			expiry_q <= s_axis_tdata[113:66];
			now_q    <= s_axis_tdata[161:114];
			lvl_q    <= s_axis_tdata[16] ? LVL_BE : '0;
		end else if (state_q == ST_CLASSIFY && cls_res.done) begin
			lvl_q <= cls_res.level[LIW-1:0];
		end else if (state_q == ST_CHECK) begin
			lvl_q <= lo_lvl;
		end else if (state_q == ST_SCAN) begin
			lvl_q <= hi_lvl;
		end
		if (state_q == ST_POP_RD) begin
			slot_q <= head_q[lvl_q];
		end
	end

	// level table, free slot bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			total_q     <= '0;
			sp_q        <= '0;
			fresh_q     <= '0;
			nres_q      <= '0;
			out_valid_q <= 1'b0;
			out_ev_q    <= EV_NOTHING;
			out_id_q    <= '0;
			out_lvl_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer) begin
				nres_q <= '0;
			end
			if (state_q == ST_LINK) begin
				if (sp_q != '0) begin
					sp_q <= sp_q - (SW+1)'(1);
				end else begin
					fresh_q <= fresh_q + (SW+1)'(1);
				end
				if (cnt_q[lvl_q] == '0) begin
					head_q[lvl_q] <= new_slot;
				end
				tail_q[lvl_q] <= new_slot;
				cnt_q[lvl_q]  <= cnt_q[lvl_q] + CW'(1);
				total_q       <= total_q + CW'(1);
			end
			if (state_q == ST_EMPTY && out_free) begin
				out_ev_q    <= EV_NOTHING;
				out_id_q    <= '0;
				out_lvl_q   <= '0;
				out_last_q  <= 1'b1;
			end
			if (state_q == ST_POP_WB && out_free) begin
				head_q[lvl_q] <= lram_rdata;
				cnt_q[lvl_q]  <= cnt_q[lvl_q] - CW'(1);
				total_q       <= total_q - CW'(1);
				sp_q          <= sp_q + (SW+1)'(1);
				nres_q        <= nres_q + NRES_W'(1);
				out_id_q      <= dram_rdata[ID_W-1:0];
				out_lvl_q     <= LEVEL_W'(lvl_q);
				if (!kind_q) begin
					out_ev_q   <= EV_OVERFLOW;
					out_last_q <= 1'b1;
				end else if (expired) begin
					out_ev_q   <= EV_EXPIRED;
					out_last_q <= nres_q == NRES_LAST;
				end else begin
					out_ev_q   <= EV_DELIVERED;
					out_last_q <= 1'b1;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_lvl_q, out_id_q};
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/core/spmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module spmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/spmq_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_classify
// slack threshold walk, one level per cycle while no threshold write comes in, and threshold adaptation
// ----------------------------------------------------------------------------
module spmq_classify import spmq_pkg::*; #(
	parameter int NUM_LEVELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cls_req_t          req,
	input  logic [QL_W-1:0]   queue_limit,
	input  logic              thr_wr,
	input  logic [TIME_W-1:0] thr_wdata,
	output cls_res_t          res
);

	localparam logic [LEVEL_W-1:0] TOP_LVL = LEVEL_W'(1);
	localparam logic [LEVEL_W-1:0] BOT_LVL = LEVEL_W'(NUM_LEVELS - 2);

	logic [TIME_W-1:0]  thr_q;
	logic [MISS_W-1:0]  mtop_q;
	logic [MISS_W-1:0]  mbot_q;
	logic               busy_q;
	logic [LEVEL_W-1:0] p_q;
	logic [TIME_W:0]    walk_q;
	logic [TIME_W-1:0]  slack_q;

	logic               lt;
	logic               hit;
	logic [MISS_W-1:0]  mtop_n;
	logic [MISS_W-1:0]  mbot_n;
	logic               grow;
	logic               shrink;
	logic [TIME_W-1:0]  thr_a;
	logic [TIME_W-1:0]  thr_b;

	always_comb begin
		lt     = slack_q[TIME_W-1] || ({1'b0, slack_q} < walk_q);
		hit    = lt || (p_q == BOT_LVL);
		mtop_n = (p_q == TOP_LVL) ? '0 : mtop_q + MISS_W'(1);
		mbot_n = (p_q == BOT_LVL) ? '0 : mbot_q + MISS_W'(1);
		grow   = mtop_n > MISS_W'(queue_limit);
		shrink = mbot_n > MISS_W'(queue_limit);
		thr_a  = thr_q;
		if (grow) begin
			thr_a = thr_q[TIME_W-1] ? THR_MAX : {thr_q[TIME_W-2:0], 1'b0};
		end
		thr_b = thr_a;
		if (shrink) begin
			thr_b = (thr_a[TIME_W-1:1] == '0) ? TIME_W'(1) : {1'b0, thr_a[TIME_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			mtop_q    <= '0;
			mbot_q    <= '0;
			busy_q    <= 1'b0;
			p_q       <= TOP_LVL;
			walk_q    <= '0;
			slack_q   <= '0;
			res.done  <= 1'b0;
			res.level <= '0;
		end else begin
			res.done <= !thr_wr && !req.start && busy_q && hit;
			if (thr_wr) begin
				thr_q <= (thr_wdata == '0) ? TIME_W'(1) : thr_wdata;
			end else if (req.start) begin
				busy_q  <= 1'b1;
				p_q     <= TOP_LVL;
				walk_q  <= {1'b0, thr_q};
				slack_q <= req.slack;
			end else if (busy_q) begin
				if (hit) begin
					busy_q    <= 1'b0;
					res.level <= p_q;
					mtop_q    <= grow ? '0 : mtop_n;
					mbot_q    <= shrink ? '0 : mbot_n;
					thr_q     <= thr_b;
				end else begin
					p_q    <= p_q + LEVEL_W'(1);
					walk_q <= walk_q[TIME_W] ? walk_q : {walk_q[TIME_W-1:0], 1'b0};
				end
			end
		end
	end

endmodule

FILE: rtl/core/spmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_checker
// port level checks of the queue core, bound to the top level
// ----------------------------------------------------------------------------
module spmq_checker import spmq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         pready,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [23:0]  m_axis_tdata,
	input logic [1:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is at work");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == EV_DELIVERED || m_axis_tuser == EV_OVERFLOW
		|| m_axis_tuser == EV_NOTHING) |-> m_axis_tlast)
		else $error("final result without tlast");

	a_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_NOTHING |-> m_axis_tdata == '0 && pready)
		else $error("empty result carries data");

endmodule

bind slack_priority_multilevel_queue_core spmq_checker u_spmq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

FILE: sim/slack_priority_multilevel_queue_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slack_priority_multilevel_queue_core_checker
// predicts the result stream of the multilevel queue from the accepted
// commands and register writes, and compares every result transfer with it
// ----------------------------------------------------------------------------
module slack_priority_multilevel_queue_core_checker import spmq_pkg::*; #(
	parameter int NUM_LEVELS = 8,
	parameter int MAX_OUT    = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	input  logic         pready,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [167:0] s_axis_tdata,
	input  logic [0:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [23:0]  m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           errors,
	output int           pending
);

	localparam int LVL_DEPTH = 64;
	localparam int OUT_DEPTH = 256;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] deadline;
		logic              can_expire;
	} queued_pkt_t;

	typedef struct {
		event_t             ev;
		logic [ID_W-1:0]    id;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} outcome_t;

	// one ring per level and one ring of predicted results
	queued_pkt_t       lvl_buf [NUM_LEVELS][LVL_DEPTH];
	int                lvl_rd [NUM_LEVELS];
	int                lvl_n [NUM_LEVELS];
	outcome_t          out_buf [OUT_DEPTH];
	int                out_rd;
	int                out_n;
	logic [QL_W-1:0]   qlimit;
	logic [TIME_W-1:0] threshold;
	int                top_misses;
	int                bottom_misses;

	assign pending = out_n;

	function automatic void lvl_append(int l, queued_pkt_t q);
		lvl_buf[l][(lvl_rd[l] + lvl_n[l]) % LVL_DEPTH] = q;
		lvl_n[l]++;
	endfunction

	function automatic queued_pkt_t lvl_take(int l);
		queued_pkt_t q;
		q = lvl_buf[l][lvl_rd[l]];
		lvl_rd[l] = (lvl_rd[l] + 1) % LVL_DEPTH;
		lvl_n[l]--;
		return q;
	endfunction

	function automatic outcome_t outcome_take();
		outcome_t o;
		o = out_buf[out_rd];
		out_rd = (out_rd + 1) % OUT_DEPTH;
		out_n--;
		return o;
	endfunction

	function automatic int held_total();
		int n;
		n = 0;
		for (int l = 0; l < NUM_LEVELS; l++)
			n += lvl_n[l];
		return n;
	endfunction

	function automatic int slack_level(logic [TIME_W-1:0] raw);
		longint s;
		longint t;
		int     p;
		s = $signed(raw);
		t = longint'({16'b0, threshold});
		p = 1;
		while (p < NUM_LEVELS - 2 && !(s < t)) begin
			t = t * 2;
			p++;
		end
		top_misses    = (p == 1) ? 0 : top_misses + 1;
		bottom_misses = (p == NUM_LEVELS - 2) ? 0 : bottom_misses + 1;
		if (top_misses > qlimit) begin
			top_misses = 0;
			threshold  = (threshold > (THR_MAX >> 1)) ? THR_MAX : threshold << 1;
		end
		if (bottom_misses > qlimit) begin
			bottom_misses = 0;
			threshold     = threshold >> 1;
			if (threshold == '0)
				threshold = 1;
		end
		return p;
	endfunction

	function automatic void add_outcome(event_t ev, logic [ID_W-1:0] id, int lvl, logic last);
		outcome_t o;
		o.ev    = ev;
		o.id    = id;
		o.level = lvl[LEVEL_W-1:0];
		o.last  = last;
		out_buf[(out_rd + out_n) % OUT_DEPTH] = o;
		out_n++;
	endfunction

	function automatic void enqueue_pkt(logic [167:0] d);
		queued_pkt_t q;
		int          lvl;
		int          cap;
		q.id         = d[15:0];
		q.can_expire = d[16];
		q.deadline   = d[113:66];
		if (!d[16])
			lvl = 0;
		else if (d[17])
			lvl = NUM_LEVELS - 1;
		else
			lvl = slack_level(d[65:18]);
		lvl_append(lvl, q);
		cap = (qlimit < 63) ? qlimit : 63;
		if (held_total() > cap) begin
			for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
				if (lvl_n[l] > 0) begin
					q = lvl_take(l);
					add_outcome(EV_OVERFLOW, q.id, l, 1'b1);
					break;
				end
			end
		end
	endfunction

	function automatic void serve(logic [TIME_W-1:0] now);
		queued_pkt_t q;
		int          n;
		int          lvl;
		bit          done;
		n    = 0;
		done = 0;
		while (!done) begin
			lvl = -1;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				if (lvl_n[l] > 0) begin
					lvl = l;
					break;
				end
			end
			if (lvl < 0) begin
				add_outcome(EV_NOTHING, '0, 0, 1'b1);
				done = 1;
			end else begin
				q = lvl_take(lvl);
				if (q.can_expire && now > q.deadline) begin
					n++;
					add_outcome(EV_EXPIRED, q.id, lvl, n == MAX_OUT);
					if (n == MAX_OUT)
						done = 1;
				end else begin
					add_outcome(EV_DELIVERED, q.id, lvl, 1'b1);
					done = 1;
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				lvl_rd[l] = 0;
				lvl_n[l]  = 0;
			end
			out_rd        = 0;
			out_n         = 0;
			qlimit        = QL_RESET;
			threshold     = THR_RESET;
			top_misses    = 0;
			bottom_misses = 0;
			errors        = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (out_n == 0) begin
					$display("%0t: unexpected result ev=%0d id=%h lvl=%0d last=%0b", $time,
						m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tlast);
					errors++;
				end else begin
					e = outcome_take();
					if (m_axis_tuser !== e.ev) begin
						$display("%0t: event expected %0d got %0d", $time, e.ev, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[15:0] !== e.id) begin
						$display("%0t: packet id expected %h got %h", $time, e.id,
							m_axis_tdata[15:0]);
						errors++;
					end
					if (m_axis_tdata[19:16] !== e.level) begin
						$display("%0t: level expected %0d got %0d", $time, e.level,
							m_axis_tdata[19:16]);
						errors++;
					end
					if (m_axis_tlast !== e.last) begin
						$display("%0t: last expected %0b got %0b", $time, e.last, m_axis_tlast);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0])
					serve(s_axis_tdata[161:114]);
				else
					enqueue_pkt(s_axis_tdata);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == 4'd0) begin
					qlimit = pwdata[QL_W-1:0];
				end else if (paddr == 4'd8) begin
					threshold = {7'b0, pwdata[ITHR_W-1:0]};
					if (threshold == '0)
						threshold = 1;
				end
			end
		end
	end

endmodule

FILE: sim/slack_priority_multilevel_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slack_priority_multilevel_queue_core_tb
// drives enqueue and dequeue commands and register settings into the queue
// core with random gaps and back-pressure, and reports the checker's verdict
// ----------------------------------------------------------------------------
module slack_priority_multilevel_queue_core_tb;
	import spmq_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE      = 30;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// packet_id, has_delay_header, best_effort, slack, expiry_time, now
	logic [167:0] s_axis_tdata;
	// kind
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// out_packet_id, out_level
	logic [23:0]  m_axis_tdata;
	// event_res
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	int          errors;
	int          pending;
	int          quiet;
	bit          no_gaps;
	bit          hold_req;
	longint      clock_ns;
	logic [47:0] cur_thr;

	slack_priority_multilevel_queue_core dut (.*);

	slack_priority_multilevel_queue_core_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		m_axis_tready = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_axis_tready <= 0;
				repeat (400) @(negedge clk);
			end
			n = no_gaps ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				m_axis_tready <= 0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	task automatic reg_write(logic [3:0] addr, logic [63:0] value);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 0;
		penable <= 0;
	endtask

	task automatic send(bit kind, logic [15:0] id, bit hdr, bit be, logic [47:0] slack,
			logic [47:0] expiry, logic [47:0] now);
		int n;
		n = no_gaps ? 0 : $urandom_range(0, 5);
		if (n > 0) begin
			s_axis_tvalid <= 0;
			repeat (n) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {6'b0, now, expiry, slack, be, hdr, id};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle_and_configure(logic [5:0] limit, logic [40:0] thr);
		s_axis_tvalid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		reg_write(4'd0, {58'b0, limit});
		reg_write(4'd8, {23'b0, thr});
		cur_thr = (thr == 0) ? 48'd1 : {7'b0, thr};
	endtask

	function automatic logic [47:0] wide_rand();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [47:0] pick_slack();
		longint base;
		case ($urandom_range(0, 9))
			0: return wide_rand();
			1: return -48'($urandom_range(0, 100000));
			default: begin
				base = longint'({16'b0, cur_thr}) << $urandom_range(0, 5);
				return 48'(base + $urandom_range(0, 4) - 2);
			end
		endcase
	endfunction

	task automatic random_item(int enq_pct);
		logic [47:0] expiry;
		logic [47:0] now;
		int          pick;
		clock_ns += $urandom_range(0, 500);
		expiry = 48'(clock_ns + $urandom_range(0, 3000) - 1000);
		now    = 48'(clock_ns);
		if ($urandom_range(0, 9) == 0) expiry = wide_rand();
		if ($urandom_range(0, 9) == 0) now = wide_rand();
		if ($urandom_range(0, 99) < enq_pct) begin
			pick = $urandom_range(0, 9);
			send(1'b0, 16'($urandom), pick != 0, pick == 1, pick_slack(), expiry, wide_rand());
		end else begin
			send(1'b1, 16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				wide_rand(), wide_rand(), now);
		end
	endtask

	task automatic random_phase(logic [5:0] limit, logic [40:0] thr, int count, int enq_pct);
		settle_and_configure(limit, thr);
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			random_item(enq_pct);
		end
		no_gaps = 0;
	endtask

	initial begin
		clk           = 0;
		arst_n        = 0;
		psel          = 0;
		penable       = 0;
		pwrite        = 0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		no_gaps       = 0;
		hold_req      = 0;
		clock_ns      = 1000000;
		cur_thr       = THR_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset settings, directed corners
		send(1'b1, 16'h0, 1'b0, 1'b0, '0, '0, '0);
		send(1'b0, 16'hFFFF, 1'b0, 1'b0, '1, '1, '0);
		send(1'b0, 16'h0001, 1'b1, 1'b1, '0, '0, '0);
		send(1'b0, 16'h0002, 1'b1, 1'b0, 48'h7FFF_FFFF_FFFF, 48'h0, '0);
		send(1'b0, 16'h0003, 1'b1, 1'b0, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, '0);
		send(1'b0, 16'h0004, 1'b1, 1'b0, 48'd0, 48'd100, '0);
		send(1'b0, 16'h0005, 1'b1, 1'b0, 48'd49999, 48'd100, '0);
		send(1'b0, 16'h0006, 1'b1, 1'b0, 48'd50000, 48'd100, '0);
		send(1'b0, 16'h0007, 1'b1, 1'b0, 48'd200000, 48'd5000, '0);
		send(1'b0, 16'h0008, 1'b1, 1'b0, 48'd1600000, 48'd5000, '0);
		send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'd0);
		send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'd100);
		send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'd101);
		send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'hFFFF_FFFF_FFFF);
		send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'hFFFF_FFFF_FFFF);
		send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'd0);
		send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'd0);

		random_phase(6'd3, 41'd100, 50, 60);
		random_phase(6'd1, 41'h1FF_FFFF_FFFF, 40, 70);
		random_phase(6'd0, 41'd0, 40, 70);
		random_phase(6'd20, 41'd1000, 50, 60);

		// fill the queue, then stall the result side while dequeues keep coming
		settle_and_configure(6'd63, 41'd50000);
		for (int i = 0; i < 63; i++)
			send(1'b0, 16'(i), 1'b1, 1'b0, pick_slack(), 48'(i * 10), '0);
		hold_req = 1;
		for (int i = 0; i < 30; i++)
			send(1'b1, '0, 1'b0, 1'b0, '0, '0, 48'(i * 20));
		for (int i = 0; i < 34; i++)
			send(1'b1, '0, 1'b0, 1'b0, '0, '0, '1);

		random_phase(6'd63, 41'd50000, 60, 65);
		random_phase(6'd50, 41'd200, 40, 55);

		s_axis_tvalid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (250) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
